### rtl/ipv4hv_pkg.sv
// Package for the IPv4 header verifier: header geometry, expected first byte
// and the result status codes. No dependencies.
package ipv4hv_pkg;

    localparam int unsigned HEADER_BYTES = 20;
    localparam int unsigned COUNT_W      = 16;
    localparam int unsigned SUM_W        = 16;

    localparam logic [7:0]         FIRST_BYTE_EXPECTED = 8'h45;
    localparam logic [SUM_W-1:0]   ONES_NEG_ZERO       = 16'hffff;
    localparam logic [COUNT_W-1:0] COUNT_MAX           = 16'hffff;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_FIRST    = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_BAD_SUM      = 3'd4
    } t_status;

    // Packed so that status sits in the low bits of the output tdata.
    typedef struct packed {
        logic [SUM_W-1:0] header_sum;
        t_status          status;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);
    localparam int unsigned OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // Ones' complement add with end-around carry; 0xffff stays negative zero.
    function automatic logic [SUM_W-1:0] ones_add(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? (s[SUM_W-1:0] + 1'b1) : s[SUM_W-1:0];
    endfunction

endpackage

### rtl/ipv4_header_verify.sv
// IPv4 header verifier top level: byte-serial header checks and checksum.
// Depends on ipv4hv_pkg.
//
// The block takes one packet byte per cycle on the slave stream, unless input
// is held off, with tlast on the final byte, and emits one result per packet on
// the master stream. Per-byte state (count, first byte, length field, running
// ones' complement sum) is updated as each byte is accepted, and the verdict
// is formed in the same cycle as the last byte, then registered into the output
// register, or into the skid slot while that register holds a result. The skid
// slot lets bytes keep flowing while a result waits; input is held off only when
// both the output register and the skid slot hold undelivered results.
module ipv4_header_verify (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // [7:0] in_byte
    input  logic                                i_s_axis_tlast,  // last_byte
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [2:0] status, [18:3] header_sum, [23:19] zero
    output logic [ipv4hv_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import ipv4hv_pkg::*;

    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic               r_count_ovf,  n_count_ovf;
    logic [SUM_W-1:0]   r_sum,        n_sum;
    logic [7:0]         r_high_hold,  n_high_hold;
    logic [7:0]         r_first,      n_first;
    logic [15:0]        r_len,        n_len;

    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    logic    s_acc, push, pop;
    logic [SUM_W-1:0] sum_c;

    assign o_s_axis_tready = !r_skid_valid;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign push            = s_acc && i_s_axis_tlast;
    assign pop             = r_out_valid && i_m_axis_tready;

    always_comb begin
        n_first      = r_first;
        n_len        = r_len;
        n_high_hold  = r_high_hold;
        n_sum        = r_sum;
        n_count_ovf  = r_count_ovf;
        n_byte_count = r_byte_count;

        if (r_byte_count == '0) begin
            n_first = i_s_axis_tdata;
        end else if (r_byte_count == COUNT_W'(2)) begin
            n_len[15:8] = i_s_axis_tdata;
        end else if (r_byte_count == COUNT_W'(3)) begin
            n_len[7:0] = i_s_axis_tdata;
        end

        if (r_byte_count < COUNT_W'(HEADER_BYTES)) begin
            if (!r_byte_count[0]) begin
                n_high_hold = i_s_axis_tdata;
            end else begin
                n_sum = ones_add(r_sum, {r_high_hold, i_s_axis_tdata});
            end
        end

        if (r_byte_count == COUNT_MAX) begin
            n_count_ovf = 1'b1;
        end else begin
            n_byte_count = r_byte_count + 1'b1;
        end

        sum_c = ~n_sum;
        n_result.header_sum = sum_c;
        if (n_byte_count < COUNT_W'(HEADER_BYTES)) begin
            n_result.status = ST_TOO_SHORT;
        end else if (n_first != FIRST_BYTE_EXPECTED) begin
            n_result.status = ST_BAD_FIRST;
        end else if (n_count_ovf || (n_len != n_byte_count)) begin
            n_result.status = ST_LEN_MISMATCH;
        end else if ((sum_c != '0) && (sum_c != ONES_NEG_ZERO)) begin
            n_result.status = ST_BAD_SUM;
        end else begin
            n_result.status = ST_OK;
        end
    end

    // Per-packet state; cleared after each last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_count_ovf  <= 1'b0;
            r_sum        <= '0;
            r_high_hold  <= '0;
            r_first      <= '0;
            r_len        <= '0;
        end else if (s_acc) begin
            if (i_s_axis_tlast) begin
                r_byte_count <= '0;
                r_count_ovf  <= 1'b0;
                r_sum        <= '0;
                r_high_hold  <= '0;
                r_first      <= '0;
                r_len        <= '0;
            end else begin
                r_byte_count <= n_byte_count;
                r_count_ovf  <= n_count_ovf;
                r_sum        <= n_sum;
                r_high_hold  <= n_high_hold;
                r_first      <= n_first;
                r_len        <= n_len;
            end
        end
    end

    // Output register with a one-entry skid slot behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out);

    // The skid slot only fills behind a held result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a result while output register is empty");

    // A packet's state is cleared in the cycle after its last byte is accepted.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_byte_count == '0) && !r_count_ovf && (r_sum == '0))
        else $error("packet state not cleared after last byte");

    // Overflow is only flagged once the byte counter has saturated.
    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_ovf |-> (r_byte_count == COUNT_MAX))
        else $error("count overflow set without saturated counter");

    // A passing verdict always carries a zero or negative-zero checksum complement.
    a_ok_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ST_OK)) |->
            ((r_out.header_sum == '0) || (r_out.header_sum == ONES_NEG_ZERO)))
        else $error("ok status with nonzero header sum");

endmodule

### bench/tb.sv
// Self-checking testbench for ipv4_header_verify: streams IPv4 packets byte by byte
// and compares each verdict with a local model of the header checks.
// Depends on ipv4hv_pkg and the ipv4_header_verify RTL.
`timescale 1ns / 1ps

module tb;
    import ipv4hv_pkg::*;

    typedef logic [7:0] t_byte_q[$];

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic                  i_s_axis_tlast = 1'b0;    // last_byte
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;           // [2:0] status, [18:3] header_sum

    // Model of the per-packet state inside the block.
    logic [15:0] rx_count = '0;
    logic        rx_over = 1'b0;
    logic [15:0] rx_sum = '0;
    logic [7:0]  rx_high = '0;
    logic [7:0]  rx_first = '0;
    logic [15:0] rx_len = '0;

    t_result     verdicts_due[$];
    t_result     verdict_want;
    t_status     got_status;
    logic [15:0] got_sum;
    int unsigned fails = 0;
    int unsigned bytes_sent = 0;
    bit          quiet = 1'b0;

    ipv4_header_verify dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

    // Ones' complement word add; a sum above 0xffff wraps its carry back in.
    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > 17'h0ffff) s = s - 17'h0ffff;
        return s[15:0];
    endfunction

    // Advances the model by one accepted byte and queues the verdict on the last one.
    function automatic void track_byte(input logic [7:0] b, input logic last);
        logic [15:0] sum_c;
        t_status     st;
        t_result     r;
        if (rx_count == 16'd0) begin
            rx_first = b;
        end else if (rx_count == 16'd2) begin
            rx_len[15:8] = b;
        end else if (rx_count == 16'd3) begin
            rx_len[7:0] = b;
        end
        if (rx_count < HEADER_BYTES) begin
            if (!rx_count[0]) rx_high = b;
            else rx_sum = fold_add(rx_sum, {rx_high, b});
        end
        if (rx_count == COUNT_MAX) rx_over = 1'b1;
        else rx_count = rx_count + 16'd1;
        if (last) begin
            sum_c = ~rx_sum;
            if (rx_count < HEADER_BYTES) st = ST_TOO_SHORT;
            else if (rx_first != FIRST_BYTE_EXPECTED) st = ST_BAD_FIRST;
            else if (rx_over || rx_len != rx_count) st = ST_LEN_MISMATCH;
            else if (sum_c != 16'h0000 && sum_c != ONES_NEG_ZERO) st = ST_BAD_SUM;
            else st = ST_OK;
            r.status = st;
            r.header_sum = sum_c;
            verdicts_due.push_back(r);
            rx_count = '0;
            rx_over = 1'b0;
            rx_sum = '0;
            rx_high = '0;
            rx_first = '0;
            rx_len = '0;
        end
    endfunction

    // Sender: random idle cycles, then holds the byte until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        logic took;
        while (!quiet && $urandom_range(99) < 22) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        i_s_axis_tlast <= last;
        do begin
            @(negedge i_clk);
            took = o_s_axis_tready;
            @(posedge i_clk);
        end while (!took);
        track_byte(b, last);
        bytes_sent++;
    endtask

    // Sends n bytes: the given head first, random filler after it.
    task automatic send_packet(input t_byte_q head, input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            send_byte((i < head.size()) ? head[i] : 8'($urandom_range(255)), i == n - 1);
        end
    endtask

    // Well-formed 20-byte header with the given total length and a correct checksum.
    task automatic build_header(input logic [15:0] total, input bit all_ones,
                                output t_byte_q h);
        logic [15:0] acc;
        h.delete();
        for (int i = 0; i < HEADER_BYTES; i++) begin
            h.push_back(all_ones ? 8'hff : 8'($urandom_range(255)));
        end
        h[0] = FIRST_BYTE_EXPECTED;
        h[2] = total[15:8];
        h[3] = total[7:0];
        h[10] = 8'h00;
        h[11] = 8'h00;
        acc = '0;
        for (int i = 0; i < HEADER_BYTES; i += 2) begin
            acc = fold_add(acc, {h[i], h[i+1]});
        end
        h[10] = ~acc[15:8];
        h[11] = ~acc[7:0];
    endtask

    task automatic test_short_packets();
        t_byte_q h;
        h.delete();
        h.push_back(8'h00);
        send_packet(h, 1);
        h[0] = 8'hff;
        send_packet(h, 1);
        send_packet(h, 2);
        // An odd count leaves a high byte that never gets its partner.
        build_header(16'd19, 1'b0, h);
        send_packet(h, 19);
        send_packet(h, 18);
    endtask

    task automatic test_good_headers();
        t_byte_q h;
        build_header(16'd20, 1'b0, h);
        send_packet(h, 20);
        // Filler of all ones forces an end-around carry on nearly every word.
        build_header(16'd20, 1'b1, h);
        send_packet(h, 20);
        build_header(16'd60, 1'b0, h);
        send_packet(h, 60);
    endtask

    task automatic test_bad_first_byte();
        t_byte_q h;
        build_header(16'd20, 1'b0, h);
        h[0] = 8'h46;
        send_packet(h, 20);
        h[0] = 8'h00;
        send_packet(h, 21);
        h[0] = 8'hff;
        send_packet(h, 20);
    endtask

    task automatic test_length_mismatch();
        t_byte_q h;
        build_header(16'd40, 1'b0, h);
        send_packet(h, 41);
        build_header(16'd19, 1'b0, h);
        send_packet(h, 20);
        build_header(16'd0, 1'b0, h);
        send_packet(h, 20);
        build_header(16'd21, 1'b0, h);
        send_packet(h, 20);
    endtask

    task automatic test_bad_checksum();
        t_byte_q h;
        build_header(16'd20, 1'b0, h);
        h[12] = h[12] ^ 8'h01;
        send_packet(h, 20);
        build_header(16'd32, 1'b0, h);
        h[19] = h[19] ^ 8'h80;
        send_packet(h, 32);
        // With the length also wrong, the length check reports first.
        send_packet(h, 33);
    endtask

    task automatic test_random_traffic();
        t_byte_q     h;
        t_byte_q     none;
        int unsigned start;
        int unsigned kind;
        int unsigned n;
        int unsigned pos;
        start = bytes_sent;
        none.delete();
        while (bytes_sent < start + 1100) begin
            quiet = (bytes_sent > start + 500) && (bytes_sent < start + 800);
            kind = $urandom_range(99);
            n = $urandom_range(64, 20);
            if (kind < 65) begin
                build_header(16'(n), 1'b0, h);
                send_packet(h, n);
            end else if (kind < 77) begin
                build_header(16'(n), 1'b0, h);
                pos = $urandom_range(HEADER_BYTES - 1);
                h[pos] = h[pos] ^ (8'h01 << $urandom_range(7));
                send_packet(h, n);
            end else if (kind < 87) begin
                build_header(16'(n), 1'b0, h);
                send_packet(h, $urandom_range(1) ? n + 1 : n - 1);
            end else begin
                send_packet(none, $urandom_range(64, 1));
            end
        end
        quiet = 1'b0;
    endtask

    // Receiver stalls at random except during quiet stretches.
    always @(posedge i_clk) begin
        i_m_axis_tready <= quiet || ($urandom_range(99) >= 22);
    end

    // Outputs are stable at the falling edge; a transaction seen here completes
    // at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_status = t_status'(o_m_axis_tdata[2:0]);
            got_sum = o_m_axis_tdata[18:3];
            if (verdicts_due.size() == 0) begin
                $error("status: no verdict pending, expected none, actual %0d", got_status);
                fails++;
            end else begin
                verdict_want = verdicts_due.pop_front();
                if (got_status != verdict_want.status) begin
                    $error("status: expected %0d, actual %0d", verdict_want.status, got_status);
                    fails++;
                end
                if (got_sum != verdict_want.header_sum) begin
                    $error("header_sum: expected %h, actual %h",
                           verdict_want.header_sum, got_sum);
                    fails++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_packets();
        test_good_headers();
        test_bad_first_byte();
        test_length_mismatch();
        test_bad_checksum();
        test_random_traffic();
        i_s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
